[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; simulation sees the checks, synthesis sees empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define SG_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define SG_ASSERT(lbl, clk, rst_n, prop)
`define SG_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[rtl/sgpt_pkg.sv]
// sgpt_pkg: constants, microcode word layout and control store for the
// sophie germain prime test unit; no dependencies
`default_nettype none

package sgpt_pkg;

  localparam int unsigned NumWidthDef = 32;
  localparam int unsigned CandWidth   = 31;
  localparam int unsigned InDataW     = 32;
  localparam int unsigned OutDataW    = 8;
  localparam int unsigned PcW         = 4;

  // datapath operation of one control word
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_D,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_D_ADD2,
    OP_PASS,
    OP_EMIT
  } op_e;

  // jump condition of one control word
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_LT2,
    C_LE3,
    C_EVEN,
    C_DIV_MORE,
    C_D_GT_Q,
    C_REM_ZERO,
    C_SECOND,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PcW-1:0]  target;
  } ucode_t;

  // program step addresses
  localparam logic [PcW-1:0] StepWait   = 4'd0;
  localparam logic [PcW-1:0] StepTest   = 4'd1;
  localparam logic [PcW-1:0] StepLe3    = 4'd2;
  localparam logic [PcW-1:0] StepEven   = 4'd3;
  localparam logic [PcW-1:0] StepInitD  = 4'd4;
  localparam logic [PcW-1:0] StepDivGo  = 4'd5;
  localparam logic [PcW-1:0] StepDiv    = 4'd6;
  localparam logic [PcW-1:0] StepBound  = 4'd7;
  localparam logic [PcW-1:0] StepRem    = 4'd8;
  localparam logic [PcW-1:0] StepNextD  = 4'd9;
  localparam logic [PcW-1:0] StepPass   = 4'd10;
  localparam logic [PcW-1:0] StepAgain  = 4'd11;
  localparam logic [PcW-1:0] StepDone   = 4'd12;
  localparam logic [PcW-1:0] StepWrap   = 4'd13;
  localparam logic [PcW-1:0] StepLast   = StepWrap;

  // control store: jump to target when the condition holds, else fall through
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: StepWait};
    unique case (pc)
      StepWait:  w = '{op: OP_LOAD,      cond: C_NO_INPUT, target: StepWait};
      StepTest:  w = '{op: OP_NONE,      cond: C_LT2,      target: StepDone};
      StepLe3:   w = '{op: OP_NONE,      cond: C_LE3,      target: StepPass};
      StepEven:  w = '{op: OP_NONE,      cond: C_EVEN,     target: StepDone};
      StepInitD: w = '{op: OP_INIT_D,    cond: C_NEVER,    target: StepWait};
      StepDivGo: w = '{op: OP_DIV_START, cond: C_NEVER,    target: StepWait};
      StepDiv:   w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: StepDiv};
      StepBound: w = '{op: OP_NONE,      cond: C_D_GT_Q,   target: StepPass};
      StepRem:   w = '{op: OP_NONE,      cond: C_REM_ZERO, target: StepDone};
      StepNextD: w = '{op: OP_D_ADD2,    cond: C_ALWAYS,   target: StepDivGo};
      StepPass:  w = '{op: OP_PASS,      cond: C_SECOND,   target: StepDone};
      StepAgain: w = '{op: OP_NONE,      cond: C_ALWAYS,   target: StepTest};
      StepDone:  w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: StepDone};
      StepWrap:  w = '{op: OP_NONE,      cond: C_ALWAYS,   target: StepWait};
      default:   w = '{op: OP_NONE,      cond: C_ALWAYS,   target: StepWait};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/sophie_germain_prime_test_unit.sv]
// a candidate below 2 goes straight to the done step; otherwise the screening steps run,
// and past them a division, a bound check and a remainder check per odd trial divisor, for
// the candidate and then for 2n+1; the bit-serial divider yields quotient and remainder
// one bit a cycle, and a stall on the result channel holds the done step. one item at a
// time: once the result enters the output register, the wrap step leads back to the wait
// step for the next request. reset returns the sequencer to the wait step and empties it
`default_nettype none
`include "assert_macros.svh"

module sophie_germain_prime_test_unit
  import sgpt_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = NumWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel in
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,  // [30:0] candidate, [31] zero
  // result channel out
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output      logic [OutDataW-1:0] m_axis_tdata_o   // [0] candidate_is_prime,
                                                     // [1] germain_flag, [7:2] zero
);

  localparam int unsigned W    = NUM_WIDTH;
  localparam int unsigned CntW = $clog2(NUM_WIDTH + 1);

  // sequencer
  logic [PcW-1:0]  pc_q, pc_d;
  ucode_t          uw;
  logic            jump;

  // datapath: number under test, trial divisor, serial divider
  logic [W-1:0]    n_q, n_d;
  logic [W-1:0]    d_q, d_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W:0]      shifted;
  logic [W:0]      diff;

  // verdict flags and output register
  logic            second_q, second_d;
  logic            p_q, p_d;
  logic            g_q, g_d;
  logic            ovalid_q, ovalid_d;
  logic            oprime_q, oprime_d;
  logic            ogerm_q, ogerm_d;

  assign uw = ucode_rom(pc_q);

  // restoring division step: shift in the next dividend bit, try a subtract
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, d_q};

  // jump condition decoder
  always_comb begin
    unique case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !s_axis_tvalid_i;
      C_LT2:      jump = (n_q[W-1:1] == '0);
      C_LE3:      jump = (n_q[W-1:2] == '0);
      C_EVEN:     jump = !n_q[0];
      C_DIV_MORE: jump = (cnt_q != CntW'(1));
      C_D_GT_Q:   jump = (d_q > quo_q);
      C_REM_ZERO: jump = (rem_q == '0);
      C_SECOND:   jump = second_q;
      C_OUT_BUSY: jump = ovalid_q;
      default:    jump = 1'b1;
    endcase
  end

  assign pc_d = jump ? uw.target : pc_q + PcW'(1);

  // datapath operations
  always_comb begin
    n_d      = n_q;
    d_d      = d_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    second_d = second_q;
    p_d      = p_q;
    g_d      = g_q;
    oprime_d = oprime_q;
    ogerm_d  = ogerm_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;

    unique case (uw.op)
      OP_NONE: ;
      OP_LOAD: begin
        if (s_axis_tvalid_i) begin
          // reduce to the arithmetic width
          n_d      = W'(s_axis_tdata_i[CandWidth-1:0]);
          second_d = 1'b0;
          p_d      = 1'b0;
          g_d      = 1'b0;
        end
      end
      OP_INIT_D: d_d = W'(3);
      OP_DIV_START: begin
        rem_d = '0;
        quo_d = n_q;
        cnt_d = CntW'(W);
      end
      OP_DIV_STEP: begin
        if (!diff[W]) begin
          rem_d = diff[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = shifted[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
      end
      OP_D_ADD2: d_d = d_q + W'(2);
      OP_PASS: begin
        if (second_q) begin
          g_d = 1'b1;
        end else begin
          // candidate is prime, go on with 2n+1 wrapped to the width
          p_d      = 1'b1;
          second_d = 1'b1;
          n_d      = {n_q[W-2:0], 1'b1};
        end
      end
      OP_EMIT: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          oprime_d = p_q;
          ogerm_d  = g_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= StepWait;
      ovalid_q <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    d_q      <= d_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    second_q <= second_d;
    p_q      <= p_d;
    g_q      <= g_d;
    oprime_q <= oprime_d;
    ogerm_q  <= ogerm_d;
  end

  assign s_axis_tready_o = (pc_q == StepWait);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {{(OutDataW-2){1'b0}}, ogerm_q, oprime_q};

  // a result enters the output register only from the final step
  `SG_ASSERT(a_emit_from_done, clk_i, rst_ni,
             $rose(ovalid_q) |-> ($past(pc_q) == StepDone))
  // a germain verdict always comes with a prime candidate
  `SG_NEVER(a_germ_needs_prime, clk_i, rst_ni, ovalid_q && ogerm_q && !oprime_q)
  // divider steps only run with a live count and an odd divisor from three up
  `SG_ASSERT(a_div_sane, clk_i, rst_ni,
             (pc_q == StepDiv) |-> ((cnt_q != '0) && d_q[0] && (d_q >= W'(3))))
  // the program counter stays within the control store
  `SG_NEVER(a_pc_range, clk_i, rst_ni, pc_q > StepLast)

endmodule

`default_nettype wire

[test/tb_sophie_germain_prime_test_unit.sv]
// testbench for sophie_germain_prime_test_unit: streams candidates in, checks the
// prime and germain verdicts against a trial-division model kept in a small class
// depends on sgpt_pkg and the unit under test only

module tb_sophie_germain_prime_test_unit;
  import sgpt_pkg::*;

  // verdict owed for one accepted request
  typedef struct {
    logic [CandWidth-1:0] cand;
    logic                 cand_prime;
    logic                 germain;
  } verdict_t;

  class germain_scoreboard;
    verdict_t owed_verdicts[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // odd divisors from three while d*d <= n
    function bit trial_division_prime(logic [NumWidthDef-1:0] n);
      logic [NumWidthDef-1:0] d;
      if (n < 2) return 1'b0;
      if (n == 2 || n == 3) return 1'b1;
      if (!n[0]) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_candidate(logic [CandWidth-1:0] cand);
      verdict_t v;
      logic [NumWidthDef-1:0] n;
      logic [NumWidthDef-1:0] twice_plus_one;
      n = NumWidthDef'(cand);
      // 2n+1 wraps like an adder of the arithmetic width
      twice_plus_one = {n[NumWidthDef-2:0], 1'b1};
      v.cand = cand;
      v.cand_prime = trial_division_prime(n);
      // composite candidate: 2n+1 is never looked at
      v.germain = v.cand_prime ? trial_division_prime(twice_plus_one) : 1'b0;
      owed_verdicts.push_back(v);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      verdict_t v;
      if (owed_verdicts.size() == 0) begin
        $error("result with no request outstanding: tdata %0h", data);
        failures++;
        return;
      end
      v = owed_verdicts.pop_front();
      if (data[0] !== v.cand_prime) begin
        $error("candidate_is_prime (candidate %0d): expected %0b, got %0b",
               v.cand, v.cand_prime, data[0]);
        failures++;
      end
      if (data[1] !== v.germain) begin
        $error("germain_flag (candidate %0d): expected %0b, got %0b",
               v.cand, v.germain, data[1]);
        failures++;
      end
    endfunction

    function int outstanding();
      return owed_verdicts.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;     // [30:0] candidate, [31] zero
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;          // [0] candidate_is_prime, [1] germain_flag

  germain_scoreboard board = new();

  // idle bursts on both sides until the closing stretch of the run
  bit          idle_bursts = 1'b1;
  int unsigned stall_left = 0;

  always #5 clk_i = ~clk_i;

  sophie_germain_prime_test_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // offer one request, optionally after a gap, and hold it until taken
  task automatic send_candidate(input logic [CandWidth-1:0] cand);
    @(negedge clk_i);
    if (idle_bursts && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {1'b0, CandWidth'($urandom)};
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, cand};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_candidate(cand);
  endtask

  // mostly cheap candidates; wide ones are multiples of three so they fail fast
  function automatic logic [CandWidth-1:0] pick_candidate();
    int unsigned sel;
    logic [CandWidth-1:0] r;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      r = CandWidth'($urandom_range(1, 4095));
    end else if (sel < 80) begin
      r = CandWidth'($urandom_range(4096, 1 << 18));
    end else begin
      r = CandWidth'($urandom);
      r = r - CandWidth'(r % 3);
      if (r < 31'd9) r = 31'd9;
    end
    return r;
  endfunction

  // result side: stalls tend to land while a result is waiting
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_bursts && ((m_axis_tvalid && $urandom_range(0, 1) == 0) ||
                                 $urandom_range(0, 15) == 0)) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // zero and one, small primes with and without a prime 2n+1, squares of primes
  // (d*d == n), the field maximum (a large prime) and single and patterned high bits
  logic [CandWidth-1:0] directed_cands[] = '{
    31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd7, 31'd9, 31'd11, 31'd23,
    31'd25, 31'd49, 31'd89, 31'd1013, 31'd65535, 31'd65537, 31'd1018081,
    31'd2147483647, 31'd2147483646, 31'd1073741824, 31'd1431655765, 31'd715827882
  };

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_cands[i]) send_candidate(directed_cands[i]);

    for (int i = 0; i < 78; i++) begin
      if (i == 60) idle_bursts = 1'b0;
      send_candidate(pick_candidate());
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk_i);
    // watch a while longer for any stray result
    repeat (100) @(posedge clk_i);

    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // guard against a hang; the field maximum alone tries every odd divisor up to its square root
  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
